@@ hdl/gsf_pkg.sv @@
// Shared types and constants for the Gouraud span fill block.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package gsf_pkg;

    // Default values of the top-level parameters
    localparam int MAX_SPAN_DEF      = 64;
    localparam int ROW_WIDTH_DEF     = 4096;
    localparam int FRACTION_BITS_DEF = 16;

    // Largest MAX_SPAN supported; sizes the pixel count field
    localparam int MAX_SPAN_TOP = 64;

    // Field widths fixed by the interface
    localparam int X_W   = 12;
    localparam int EX_W  = 13;
    localparam int CH_W  = 32;
    localparam int COL_W = 24;
    localparam int CNT_W = $clog2(MAX_SPAN_TOP + 1);

    // Width used for column arithmetic, wide enough for ROW_WIDTH up to 65536
    localparam int XA_W = 17;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Saturation value of one colour channel
    localparam logic [7:0] BYTE_MAX = 8'hFF;

    // One classified, non-empty span as handed from front to back
    typedef struct packed {
        logic [X_W-1:0]   sx;
        logic [CNT_W-1:0] cnt;
        logic             clipped;
        logic [CH_W-1:0]  r;
        logic [CH_W-1:0]  g;
        logic [CH_W-1:0]  b;
        logic [CH_W-1:0]  dr;
        logic [CH_W-1:0]  dg;
        logic [CH_W-1:0]  db;
    } t_span;

endpackage

`default_nettype wire

@@ hdl/gsf_front.sv @@
// Front end of the span fill: accepts span requests, clips them to the row
// and to the span limit, drops empty ones. Depends on gsf_pkg.
`default_nettype none

module gsf_front #(
    parameter int MAX_SPAN  = gsf_pkg::MAX_SPAN_DEF,
    parameter int ROW_WIDTH = gsf_pkg::ROW_WIDTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic [gsf_pkg::X_W-1:0]  i_start_x,
    input  wire logic [gsf_pkg::EX_W-1:0] i_end_x,
    input  wire logic [gsf_pkg::CH_W-1:0] i_red_start,
    input  wire logic [gsf_pkg::CH_W-1:0] i_green_start,
    input  wire logic [gsf_pkg::CH_W-1:0] i_blue_start,
    input  wire logic [gsf_pkg::CH_W-1:0] i_red_step,
    input  wire logic [gsf_pkg::CH_W-1:0] i_green_step,
    input  wire logic [gsf_pkg::CH_W-1:0] i_blue_step,
    output logic                          o_push_valid,
    input  wire logic                     i_push_ready,
    output gsf_pkg::t_span                o_push_span
);
    import gsf_pkg::*;

    localparam logic [XA_W-1:0] ROW_L  = XA_W'(ROW_WIDTH);
    localparam logic [XA_W-1:0] SPAN_L = XA_W'(MAX_SPAN);

    logic            r_vld;
    t_span           r_span;
    logic [XA_W-1:0] sx_ext;
    logic [XA_W-1:0] ex_ext;
    logic [XA_W-1:0] ex_cut;
    logic [XA_W-1:0] len;
    logic            empty;
    logic            clip;
    t_span           n_span;

    always_comb begin
        sx_ext = XA_W'(i_start_x);
        ex_ext = XA_W'(i_end_x);
        ex_cut = (ex_ext > ROW_L) ? ROW_L : ex_ext;
        empty  = (ex_cut <= sx_ext);
        len    = ex_cut - sx_ext;
        clip   = (len > SPAN_L);
        n_span.sx      = i_start_x;
        n_span.cnt     = clip ? CNT_W'(MAX_SPAN) : len[CNT_W-1:0];
        n_span.clipped = clip;
        n_span.r       = i_red_start;
        n_span.g       = i_green_start;
        n_span.b       = i_blue_start;
        n_span.dr      = i_red_step;
        n_span.dg      = i_green_step;
        n_span.db      = i_blue_step;
    end

    assign o_ready      = !r_vld || i_push_ready;
    assign o_push_valid = r_vld;
    assign o_push_span  = r_span;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_valid && o_ready) begin
            // drop empty spans here
            r_vld  <= !empty;
            r_span <= n_span;
        end else if (i_push_ready) begin
            r_vld <= 1'b0;
        end
    end

endmodule

`default_nettype wire

@@ hdl/gsf_fifo.sv @@
// Short queue of classified spans between front and back.
// Depends on gsf_pkg for the span type.
`default_nettype none

module gsf_fifo #(
    parameter int DEPTH = gsf_pkg::QUEUE_DEPTH
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push_valid,
    output logic           o_push_ready,
    input  gsf_pkg::t_span i_push_span,
    output logic           o_pop_valid,
    input  wire logic      i_pop_ready,
    output gsf_pkg::t_span o_pop_span
);
    import gsf_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_span         r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          push;
    logic          pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_span   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_mem[r_wr_ptr] <= i_push_span;
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CW'(push) - CW'(pop);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("span queue count beyond depth");

endmodule

`default_nettype wire

@@ hdl/gsf_back.sv @@
// Back end of the span fill: steps the three colour accumulators one pixel
// a cycle unless stalled; drives the pixel output register. Needs gsf_pkg.
`default_nettype none

module gsf_back #(
    parameter int FRACTION_BITS = gsf_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_pop_valid,
    output logic                            o_pop_ready,
    input  gsf_pkg::t_span                  i_pop_span,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [gsf_pkg::X_W-1:0]         o_pixel_x,
    output logic [gsf_pkg::COL_W-1:0]       o_pixel_color,
    output logic                            o_last_pixel,
    output logic                            o_span_clipped
);
    import gsf_pkg::*;

    function automatic logic [7:0] chan_byte(input logic [CH_W-1:0] v);
        logic [CH_W-1:0] q;
        q = v >> FRACTION_BITS;
        if (v[CH_W-1]) begin
            return 8'h00;
        end else if (q > CH_W'(BYTE_MAX)) begin
            return BYTE_MAX;
        end
        return q[7:0];
    endfunction

    logic             r_busy;
    logic [X_W-1:0]   r_x;
    logic [CNT_W-1:0] r_remain;
    logic             r_clipped;
    logic [CH_W-1:0]  r_r, r_g, r_b;
    logic [CH_W-1:0]  r_dr, r_dg, r_db;
    logic             r_out_vld;
    logic [X_W-1:0]   r_out_x;
    logic [COL_W-1:0] r_out_col;
    logic             r_out_last;
    logic             r_out_clip;
    logic             can_emit;
    logic             is_last;
    logic             load;

    assign can_emit    = r_busy && (!r_out_vld || i_ready);
    assign is_last     = (r_remain == CNT_W'(1));
    assign o_pop_ready = !r_busy || (can_emit && is_last);
    assign load        = i_pop_valid && o_pop_ready;

    assign o_valid        = r_out_vld;
    assign o_pixel_x      = r_out_x;
    assign o_pixel_color  = r_out_col;
    assign o_last_pixel   = r_out_last;
    assign o_span_clipped = r_out_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (can_emit) begin
                r_out_vld  <= 1'b1;
                r_out_x    <= r_x;
                r_out_col  <= {chan_byte(r_r), chan_byte(r_g), chan_byte(r_b)};
                r_out_last <= is_last;
                r_out_clip <= is_last && r_clipped;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
            if (load) begin
                r_busy    <= 1'b1;
                r_x       <= i_pop_span.sx;
                r_remain  <= i_pop_span.cnt;
                r_clipped <= i_pop_span.clipped;
                r_r       <= i_pop_span.r;
                r_g       <= i_pop_span.g;
                r_b       <= i_pop_span.b;
                r_dr      <= i_pop_span.dr;
                r_dg      <= i_pop_span.dg;
                r_db      <= i_pop_span.db;
            end else if (can_emit) begin
                r_x      <= r_x + 1'b1;
                r_remain <= r_remain - 1'b1;
                r_r      <= r_r + r_dr;
                r_g      <= r_g + r_dg;
                r_b      <= r_b + r_db;
                if (is_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    a_clip_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_clip |-> r_out_last)
        else $error("clip flag on a pixel that is not last");

    a_busy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_remain != '0)
        else $error("active span with no pixels left");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && r_busy |-> can_emit && is_last)
        else $error("new span loaded over an unfinished one");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        can_emit && is_last && !load |=> !r_busy)
        else $error("back stays busy after last pixel");

endmodule

`default_nettype wire

@@ hdl/gouraud_span_fill.sv @@
// Top level of the Gouraud span fill: front end, span queue and pixel back end.
// Depends on gsf_pkg, gsf_front, gsf_fifo and gsf_back.
//
// Usage:
//  - Input channel (i_valid / o_ready) takes one span request: start column,
//    exclusive end column, and 16.16 start value and per-pixel step for red,
//    green and blue.
//  - Output channel (o_valid / i_ready) gives one pixel per handshake:
//    column, packed 0x RRGGBB colour, last-pixel and clip flags.
//  - The first pixel of a span passes the front register, the queue, the
//    back load and the output register in that order, if the path is free.
//  - Throughput: the back end produces one pixel a cycle unless the output
//    stalls; a span holds it for at most MAX_SPAN pixels, and the next span
//    from the queue loads on the cycle the last pixel is issued, with no gap.
//    Empty spans are dropped in the front end.
//  - A stalled receiver holds the output register; the back end then waits,
//    the two-entry queue fills, and o_ready falls once front and queue are full.
//  - Reset (synchronous, active low) empties the front register, the queue
//    and the output register; no span is in flight afterwards.
`default_nettype none

module gouraud_span_fill #(
    parameter int MAX_SPAN      = gsf_pkg::MAX_SPAN_DEF,
    parameter int ROW_WIDTH     = gsf_pkg::ROW_WIDTH_DEF,
    parameter int FRACTION_BITS = gsf_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [gsf_pkg::X_W-1:0]    i_start_x,
    input  wire logic [gsf_pkg::EX_W-1:0]   i_end_x,
    input  wire logic [gsf_pkg::CH_W-1:0]   i_red_start,
    input  wire logic [gsf_pkg::CH_W-1:0]   i_green_start,
    input  wire logic [gsf_pkg::CH_W-1:0]   i_blue_start,
    input  wire logic [gsf_pkg::CH_W-1:0]   i_red_step,
    input  wire logic [gsf_pkg::CH_W-1:0]   i_green_step,
    input  wire logic [gsf_pkg::CH_W-1:0]   i_blue_step,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [gsf_pkg::X_W-1:0]         o_pixel_x,
    output logic [gsf_pkg::COL_W-1:0]       o_pixel_color,
    output logic                            o_last_pixel,
    output logic                            o_span_clipped
);
    import gsf_pkg::*;

    // front to queue
    logic  push_valid;
    logic  push_ready;
    t_span push_span;

    // queue to back
    logic  pop_valid;
    logic  pop_ready;
    t_span pop_span;

    // Classify the request: cut to the row, cut to the span limit, drop if empty
    gsf_front #(
        .MAX_SPAN  (MAX_SPAN),
        .ROW_WIDTH (ROW_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_start_x     (i_start_x),
        .i_end_x       (i_end_x),
        .i_red_start   (i_red_start),
        .i_green_start (i_green_start),
        .i_blue_start  (i_blue_start),
        .i_red_step    (i_red_step),
        .i_green_step  (i_green_step),
        .i_blue_step   (i_blue_step),
        .o_push_valid  (push_valid),
        .i_push_ready  (push_ready),
        .o_push_span   (push_span)
    );

    // Hold classified spans so the front keeps accepting while the back is busy
    gsf_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_span  (push_span),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_span   (pop_span)
    );

    // Advance the accumulators one pixel a cycle unless stalled and register each pixel
    gsf_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pop_valid    (pop_valid),
        .o_pop_ready    (pop_ready),
        .i_pop_span     (pop_span),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_color  (o_pixel_color),
        .o_last_pixel   (o_last_pixel),
        .o_span_clipped (o_span_clipped)
    );

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// Self-checking testbench for gouraud_span_fill: directed span table, then random spans.
// Depends on gsf_pkg and the gouraud_span_fill RTL; needs no files or arguments.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gsf_pkg::*;

    localparam int N_RANDOM    = 220;     // non-empty random spans to send
    localparam int N_DIRECTED  = 19;
    localparam int HOLDOFF     = 400;     // long output stall, in cycles
    localparam int DRAIN       = 80;      // quiet cycles after the last pixel
    localparam int LIMIT       = 400000;  // cycle budget for the whole run
    localparam int MAX_REPORTS = 10;

    // One span request as offered, with an optional typed-in expectation
    // (fixed colour on every pixel, pixel count and clip flag).
    typedef struct {
        logic [X_W-1:0]   sx;
        logic [EX_W-1:0]  ex;
        logic [CH_W-1:0]  r;
        logic [CH_W-1:0]  g;
        logic [CH_W-1:0]  b;
        logic [CH_W-1:0]  dr;
        logic [CH_W-1:0]  dg;
        logic [CH_W-1:0]  db;
        bit               fixed;
        int               fixed_n;
        logic [COL_W-1:0] fixed_col;
        bit               fixed_clip;
    } t_span_req;

    // One pixel as it should leave the block
    typedef struct {
        logic [X_W-1:0]   x;
        logic [COL_W-1:0] color;
        logic             last;
        logic             clip;
    } t_pixel;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_ready;
    logic [X_W-1:0]   i_start_x;
    logic [EX_W-1:0]  i_end_x;
    logic [CH_W-1:0]  i_red_start;
    logic [CH_W-1:0]  i_green_start;
    logic [CH_W-1:0]  i_blue_start;
    logic [CH_W-1:0]  i_red_step;
    logic [CH_W-1:0]  i_green_step;
    logic [CH_W-1:0]  i_blue_step;
    logic             o_valid;
    logic             i_ready;
    logic [X_W-1:0]   o_pixel_x;
    logic [COL_W-1:0] o_pixel_color;
    logic             o_last_pixel;
    logic             o_span_clipped;

    gouraud_span_fill dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_start_x      (i_start_x),
        .i_end_x        (i_end_x),
        .i_red_start    (i_red_start),
        .i_green_start  (i_green_start),
        .i_blue_start   (i_blue_start),
        .i_red_step     (i_red_step),
        .i_green_step   (i_green_step),
        .i_blue_step    (i_blue_step),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_color  (o_pixel_color),
        .o_last_pixel   (o_last_pixel),
        .o_span_clipped (o_span_clipped)
    );

    // Directed spans. Rows with the fixed flag carry zero steps, so every
    // pixel has the same colour and the expectation can be typed in; the
    // rest go through the predictor.
    t_span_req directed_rows [N_DIRECTED] = '{
        // single pixel, all black
        '{12'd0, 13'd1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1, 1, 24'h000000, 0},
        // empty spans: end equal to start, end below start, both at the last column
        '{12'd0, 13'd0, 32'h00FF0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
          1, 0, 24'h0, 0},
        '{12'd100, 13'd50, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1, 0, 24'h0, 0},
        '{12'd4095, 13'd4095, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1, 0, 24'h0, 0},
        // last column of the row; top of range and large positive saturate to white
        '{12'd4095, 13'd4096, 32'h00FF0000, 32'h00FFFFFF, 32'h7FFFFFFF,
          32'h0, 32'h0, 32'h0, 1, 1, 24'hFFFFFF, 0},
        // end far past the row is cut to the row without a clip flag;
        // negative channels go to zero, 256.0 saturates
        '{12'd4095, 13'd8191, 32'h80000000, 32'hFFFFFFFF, 32'h01000000,
          32'h0, 32'h0, 32'h0, 1, 1, 24'h0000FF, 0},
        // row cut and then the long-span cut: 96 pixels become 64, clipped
        '{12'd4000, 13'd8191, 32'h00800000, 32'h00400000, 32'h00010000,
          32'h0, 32'h0, 32'h0, 1, 64, 24'h804001, 1},
        // exactly MAX_SPAN pixels: not clipped
        '{12'd10, 13'd74, 32'h00120000, 32'h00340000, 32'h00560000,
          32'h0, 32'h0, 32'h0, 1, 64, 24'h123456, 0},
        // one past MAX_SPAN: clipped; fractions are dropped
        '{12'd10, 13'd75, 32'h00AB8000, 32'h00CDFFFF, 32'h00EF0001,
          32'h0, 32'h0, 32'h0, 1, 64, 24'hABCDEF, 1},
        // whole row with gradients, clipped
        '{12'd0, 13'd4096, 32'h0, 32'h00FF0000, 32'h00800000,
          32'h00040000, 32'hFFFC0000, 32'h00010000, 0, 0, 24'h0, 0},
        // ramps up into saturation
        '{12'd200, 13'd232, 32'h0, 32'h0, 32'h0,
          32'h00080000, 32'h00100000, 32'h00020000, 0, 0, 24'h0, 0},
        // ramps down through zero into negatives
        '{12'd300, 13'd340, 32'h00100000, 32'h00FF0000, 32'h00050000,
          32'hFFFF0000, 32'hFFF80000, 32'hFFFFC000, 0, 0, 24'h0, 0},
        // positive overflow wraps to negative
        '{12'd500, 13'd520, 32'h7FFF0000, 32'h7FFFFFFF, 32'h7FFE0000,
          32'h00010000, 32'h00000001, 32'h00008000, 0, 0, 24'h0, 0},
        // negative values wrap back to positive
        '{12'd600, 13'd610, 32'h80000000, 32'hFFFF0000, 32'h80000001,
          32'h7FFFFFFF, 32'h00010000, 32'hFFFFFFFF, 0, 0, 24'h0, 0},
        // extreme steps
        '{12'd700, 13'd710, 32'h0, 32'h0, 32'h0,
          32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 0, 0, 24'h0, 0},
        // fraction carries into the integer part
        '{12'd800, 13'd808, 32'h0000FFFF, 32'h00FFFFFF, 32'h0000FFFE,
          32'h00000001, 32'h00000001, 32'h00000001, 0, 0, 24'h0, 0},
        // alternating bit patterns in every field
        '{12'hAAA, 13'h0AB4, 32'hA5A5A5A5, 32'h5A5A5A5A, 32'h0F0F0F0F,
          32'h3C3C3C3C, 32'hC3C3C3C3, 32'h00FF00FF, 0, 0, 24'h0, 0},
        '{12'h555, 13'h0558, 32'h00FFFFFF, 32'h01000000, 32'h00FF8000,
          32'h00000000, 32'hFFFFFFFF, 32'h00010000, 0, 0, 24'h0, 0},
        // short span ending at the row edge
        '{12'd4090, 13'h1000, 32'h00200000, 32'h00FE0000, 32'h0,
          32'h00300000, 32'h00008000, 32'h00400000, 0, 0, 24'h0, 0}
    };

    t_span_req spans_in_flight [$];   // offered, not yet taken by the block
    t_pixel    pixels_due [$];        // predicted pixels, oldest first

    int cycles;
    int faults;
    int directed_sent;
    int random_sent;
    int empty_taken;
    int pixels_seen;
    int clipped_seen;

    // Sender pacing and receiver pattern
    bit hold_req;
    bit hold_done;
    bit holding;
    int hold_left;
    int rx_mode;
    int rx_mode_left;
    int burst_left;

    t_span_req taken;
    t_pixel    got_px;
    t_pixel    want_px;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Channel byte: negative clamps to zero, integer part above 255 saturates.
    function automatic logic [7:0] shade_byte(logic [CH_W-1:0] v);
        if (v[CH_W-1])
            return 8'h00;
        if ((v >> FRACTION_BITS_DEF) > 32'd255)
            return BYTE_MAX;
        return v[FRACTION_BITS_DEF +: 8];
    endfunction

    // Pixels a span yields once the end is cut to the row and the length
    // to MAX_SPAN; the long-span cut alone sets the clip flag.
    function automatic int span_length(t_span_req s, output bit clipped);
        int hi;
        int n;
        clipped = 0;
        hi = (int'(s.ex) > ROW_WIDTH_DEF) ? ROW_WIDTH_DEF : int'(s.ex);
        if (hi <= int'(s.sx))
            return 0;
        n = hi - int'(s.sx);
        if (n > MAX_SPAN_DEF) begin
            n = MAX_SPAN_DEF;
            clipped = 1;
        end
        return n;
    endfunction

    // Queue up every pixel a taken span should produce.
    task automatic queue_span_pixels(t_span_req s);
        int n;
        bit clip;
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
        t_pixel p;
        n = span_length(s, clip);
        if (s.fixed) begin
            n = s.fixed_n;
            clip = s.fixed_clip;
        end
        if (n == 0)
            empty_taken++;
        r = s.r;
        g = s.g;
        b = s.b;
        for (int i = 0; i < n; i++) begin
            p.x     = X_W'(int'(s.sx) + i);
            p.color = s.fixed ? s.fixed_col : {shade_byte(r), shade_byte(g), shade_byte(b)};
            p.last  = (i == n - 1);
            p.clip  = p.last && clip;
            pixels_due.push_back(p);
            r += s.dr;
            g += s.dg;
            b += s.db;
        end
    endtask

    task automatic note_fault(string msg);
        faults++;
        if (faults <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // ------------------------------------------------------------------
    // Clock and cycle budget
    // ------------------------------------------------------------------

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Sample both channels at the rising edge, in one place: take the
    // request first, then check any pixel against the oldest prediction.
    always @(posedge i_clk) begin
        cycles++;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                taken = spans_in_flight.pop_front();
                queue_span_pixels(taken);
            end
            if (o_valid && i_ready) begin
                got_px = '{o_pixel_x, o_pixel_color, o_last_pixel, o_span_clipped};
                pixels_seen++;
                if (o_span_clipped)
                    clipped_seen++;
                if (pixels_due.size() == 0) begin
                    note_fault($sformatf("unexpected pixel x=%0d colour=%h last=%b clip=%b",
                                         got_px.x, got_px.color, got_px.last, got_px.clip));
                end else begin
                    want_px = pixels_due.pop_front();
                    if (got_px.x !== want_px.x || got_px.color !== want_px.color ||
                        got_px.last !== want_px.last || got_px.clip !== want_px.clip)
                        note_fault($sformatf(
                            "pixel wrong: x %0d/%0d colour %h/%h last %b/%b clip %b/%b (exp/got)",
                            want_px.x, got_px.x, want_px.color, got_px.color,
                            want_px.last, got_px.last, want_px.clip, got_px.clip));
                end
            end
        end
        if (cycles >= LIMIT) begin
            $display("timeout after %0d cycles, %0d pixels outstanding", cycles, pixels_due.size());
            $display("gouraud_span_fill: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall pattern, plus one long hold-off once the
    // random part starts, so the queue fills and o_ready drops.
    // ------------------------------------------------------------------

    initial begin
        i_ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                holding = (hold_left > 0);
                i_ready <= 1'b0;
            end else if (hold_req && !hold_done) begin
                hold_done = 1;
                holding   = 1;
                hold_left = HOLDOFF - 1;
                i_ready <= 1'b0;
            end else begin
                // Pick a new pattern now and then: always ready, half, one in four
                if (rx_mode_left == 0) begin
                    rx_mode      = $urandom_range(0, 2);
                    rx_mode_left = $urandom_range(5, 60);
                end
                rx_mode_left--;
                case (rx_mode)
                    0:       i_ready <= 1'b1;
                    1:       i_ready <= 1'($urandom_range(0, 1));
                    default: i_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Idle between bursts; never during the hold-off, so the block fills up.
    task automatic pace_requests();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            for (int k = 0; k < gap && !holding; k++) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
            end
        end
        burst_left--;
    endtask

    // Present one request and hold it until the block takes it.
    task automatic offer_span(t_span_req s);
        pace_requests();
        @(negedge i_clk);
        spans_in_flight.push_back(s);
        i_valid       <= 1'b1;
        i_start_x     <= s.sx;
        i_end_x       <= s.ex;
        i_red_start   <= s.r;
        i_green_start <= s.g;
        i_blue_start  <= s.b;
        i_red_step    <= s.dr;
        i_green_step  <= s.dg;
        i_blue_step   <= s.db;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
    endtask

    // Start values mostly inside the visible range, sometimes at the wrap points.
    function automatic logic [CH_W-1:0] rand_start();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom_range(0, 32'h0120_0000);
            5, 6:          return $urandom();
            7:             return 32'h7FFF_0000 | $urandom_range(0, 32'hFFFF);
            8:             return 32'h8000_0000 | $urandom_range(0, 32'hFFFF);
            default:       return 32'h00FF_0000 + $urandom_range(0, 32'h1FFFF);
        endcase
    endfunction

    // Steps mostly gentle gradients of either sign.
    function automatic logic [CH_W-1:0] rand_step();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            6, 7:             return $urandom();
            8:                return 32'h0;
            default:          return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
        endcase
    endfunction

    // Mostly short spans; some empty, some past MAX_SPAN, some past the row.
    function automatic t_span_req rand_span();
        t_span_req s;
        int kind;
        int hi;
        s = '{default: 0};
        s.sx = X_W'($urandom_range(0, 4095));
        kind = $urandom_range(0, 99);
        if (kind < 8)
            hi = $urandom_range(0, s.sx);
        else if (kind < 16)
            hi = s.sx + $urandom_range(65, 300);
        else if (kind < 22)
            hi = $urandom_range(4096, 8191);
        else if (kind < 35)
            hi = s.sx + $urandom_range(21, 64);
        else
            hi = s.sx + $urandom_range(1, 20);
        s.ex = (hi > 8191) ? 13'h1FFF : EX_W'(hi);
        s.r  = rand_start();
        s.g  = rand_start();
        s.b  = rand_start();
        s.dr = rand_step();
        s.dg = rand_step();
        s.db = rand_step();
        return s;
    endfunction

    initial begin
        t_span_req s;
        bit clip;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_start_x     = '0;
        i_end_x       = '0;
        i_red_start   = '0;
        i_green_start = '0;
        i_blue_start  = '0;
        i_red_step    = '0;
        i_green_step  = '0;
        i_blue_step   = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        foreach (directed_rows[k]) begin
            offer_span(directed_rows[k]);
            directed_sent++;
        end

        // Random part; ask for the long receiver hold-off as it begins.
        // Empty spans still go out but do not count towards the total.
        hold_req = 1;
        while (random_sent < N_RANDOM) begin
            s = rand_span();
            offer_span(s);
            if (span_length(s, clip) != 0)
                random_sent++;
        end

        @(negedge i_clk);
        i_valid <= 1'b0;

        // Drain, then stay quiet long enough to catch stray pixels
        while (spans_in_flight.size() != 0 || pixels_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (pixels_due.size() != 0)
            note_fault($sformatf("%0d pixels never arrived", pixels_due.size()));

        $display("Sent %0d directed and %0d non-empty random spans (%0d empty taken), %0d pixels",
                 directed_sent, random_sent, empty_taken, pixels_seen);
        $display("Clipped spans seen: %0d; one %0d-cycle output hold-off; %0d faults",
                 clipped_seen, HOLDOFF, faults);
        if (faults == 0)
            $display("gouraud_span_fill: match");
        else
            $display("gouraud_span_fill: mismatch");
        $finish;
    end

endmodule
